// ===== hdl/sets_pkg.sv =====
// shared types and constants for the scroll edge trigger scan block
package sets_pkg;

   localparam int TRIG_BITS = 8;
   localparam int COORD_BITS = 16;
   localparam int MASK_BITS = 12;
   localparam int STRIDE_BITS = 13;
   localparam int DIM_BITS = 4;
   localparam int SUM_BITS = 25;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 13;

   localparam logic [TRIG_BITS-1:0] TRIG_EMPTY = '1;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_MOVE = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_VIEW_WIDTH = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VIEW_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAP_STRIDE = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_X_MASK = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_Y_MASK = 3'd4;

   typedef struct packed {
      logic cmd;
      logic signed [COORD_BITS-1:0] tile_x;
      logic signed [COORD_BITS-1:0] tile_y;
      logic [MASK_BITS-1:0] map_address;
      logic [TRIG_BITS-1:0] trigger_value;
   } req_word_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] out_tile_x;
      logic signed [COORD_BITS-1:0] out_tile_y;
      logic [TRIG_BITS-1:0] trigger_id;
      logic last;
   } rsp_word_type;

   typedef struct packed {
      logic start;
      logic lookup;
   } au_req_type;

endpackage

// ===== hdl/sets_map_ram.sv =====
// trigger map storage, one write port and one registered read port
module sets_map_ram #(
   parameter int MAP_DEPTH = 4096
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(MAP_DEPTH)-1:0] wr_addr,
   input  logic [sets_pkg::TRIG_BITS-1:0] wr_data,
   input  logic rd_en,
   input  logic [$clog2(MAP_DEPTH)-1:0] rd_addr,
   output logic [sets_pkg::TRIG_BITS-1:0] rd_data
);

   logic [sets_pkg::TRIG_BITS-1:0] map_mem [MAP_DEPTH];
   logic [sets_pkg::TRIG_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= map_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/sets_addr_unit.sv =====
// map address unit: stride multiply and add for lookups, then modulo reduction by the map depth
module sets_addr_unit #(
   parameter int MAP_DEPTH = 4096
) (
   input  logic clock,
   input  logic reset,
   input  sets_pkg::au_req_type au_req,
   input  logic [sets_pkg::MASK_BITS-1:0] mask_x,
   input  logic [sets_pkg::MASK_BITS-1:0] mask_y,
   input  logic [sets_pkg::STRIDE_BITS-1:0] stride,
   input  logic [sets_pkg::MASK_BITS-1:0] wr_index,
   output logic done,
   output logic [$clog2(MAP_DEPTH)-1:0] addr
);

   localparam int AW = $clog2(MAP_DEPTH);
   localparam bit IS_POW2 = (MAP_DEPTH & (MAP_DEPTH - 1)) == 0;
   localparam int SHIFT_TOP = sets_pkg::SUM_BITS - AW;
   localparam int STEP_BITS = $clog2(sets_pkg::SUM_BITS + 1);
   localparam logic [sets_pkg::SUM_BITS-1:0] DIV_TOP =
      sets_pkg::SUM_BITS'(MAP_DEPTH) << SHIFT_TOP;
   localparam logic [STEP_BITS-1:0] STEP_TOP = STEP_BITS'(SHIFT_TOP);

   typedef enum logic [4:0] {
      AU_IDLE = 5'b00001,
      AU_MUL  = 5'b00010,
      AU_ADD  = 5'b00100,
      AU_RED  = 5'b01000,
      AU_DONE = 5'b10000
   } au_state_type;

   au_state_type state_ff, state_in;
   logic [sets_pkg::MASK_BITS-1:0] mx_ff, mx_in;
   logic [sets_pkg::MASK_BITS-1:0] my_ff, my_in;
   logic [sets_pkg::STRIDE_BITS-1:0] stride_ff, stride_in;
   logic [sets_pkg::SUM_BITS-1:0] prod_ff, prod_in;
   logic [sets_pkg::SUM_BITS-1:0] sum_ff, sum_in;
   logic [sets_pkg::SUM_BITS-1:0] div_ff, div_in;
   logic [STEP_BITS-1:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      mx_in = mx_ff;
      my_in = my_ff;
      stride_in = stride_ff;
      prod_in = prod_ff;
      sum_in = sum_ff;
      div_in = div_ff;
      step_in = step_ff;
      unique case (state_ff)
         AU_IDLE: begin
            if (au_req.start) begin
               mx_in = mask_x;
               my_in = mask_y;
               stride_in = stride;
               div_in = DIV_TOP;
               step_in = STEP_TOP;
               if (au_req.lookup) begin
                  state_in = AU_MUL;
               end else begin
                  sum_in = sets_pkg::SUM_BITS'(wr_index);
                  state_in = IS_POW2 ? AU_DONE : AU_RED;
               end
            end
         end
         AU_MUL: begin
            prod_in = sets_pkg::SUM_BITS'(stride_ff) * sets_pkg::SUM_BITS'(my_ff);
            state_in = AU_ADD;
         end
         AU_ADD: begin
            sum_in = prod_ff + sets_pkg::SUM_BITS'(mx_ff);
            state_in = IS_POW2 ? AU_DONE : AU_RED;
         end
         AU_RED: begin
            if (sum_ff >= div_ff) begin
               sum_in = sum_ff - div_ff;
            end
            div_in = div_ff >> 1;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = AU_DONE;
            end
         end
         AU_DONE: begin
            state_in = AU_IDLE;
         end
         default: begin
            state_in = AU_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AU_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mx_ff <= mx_in;
      my_ff <= my_in;
      stride_ff <= stride_in;
      prod_ff <= prod_in;
      sum_ff <= sum_in;
      div_ff <= div_in;
      step_ff <= step_in;
   end

   assign done = state_ff == AU_DONE;
   assign addr = sum_ff[AW-1:0];

endmodule

// ===== hdl/scroll_edge_trigger_scan_core.sv =====
// top level: tile map, viewport origin and the scan sequencer
// After reset the block clears the whole trigger map, one entry per cycle, and
// busy stays high until the last entry is cleared. A write command runs its
// map address through the shared address unit, reduced modulo the depth only
// when MAP_DEPTH is not a power of two, and then writes the map. A move command
// scans one edge column or row, or the whole view after a larger jump, and each
// scanned tile goes through the shared address unit (multiply, add, and the
// modulo reduction steps when MAP_DEPTH is not a power of two), then a map read
// and a check. A move to the same origin is accepted but scans nothing and
// sends no word. Results leave as single-cycle strobes on rsp_valid, one word
// per found trigger, with last set on the final word of a move; they cannot be
// held off, so the receiver must take every strobe.
module scroll_edge_trigger_scan_core #(
   parameter int MAP_DEPTH = 4096,
   parameter int VIEW_MAX = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  sets_pkg::req_word_type req,
   output logic rsp_valid,
   output sets_pkg::rsp_word_type rsp,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [sets_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sets_pkg::CSR_DATA_BITS-1:0] csr_data
);

   localparam int AW = $clog2(MAP_DEPTH);
   localparam int CB = sets_pkg::COORD_BITS;
   localparam int DB = sets_pkg::DIM_BITS;
   localparam int MB = sets_pkg::MASK_BITS;
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_DEPTH - 1);
   localparam logic [DB-1:0] VIEW_LIMIT = DB'(VIEW_MAX);
   localparam logic [CB:0] DELTA_ZERO = '0;
   localparam logic [CB:0] DELTA_ONE = (CB + 1)'(1);
   localparam logic [CB:0] DELTA_MINUS_ONE = '1;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_WADDR = 7'b0000100,
      ST_LOOK  = 7'b0001000,
      ST_ADDR  = 7'b0010000,
      ST_EVAL  = 7'b0100000,
      ST_FLUSH = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [DB-1:0] view_width_ff, view_height_ff;
   logic [sets_pkg::STRIDE_BITS-1:0] map_stride_ff;
   logic [MB-1:0] x_mask_ff, y_mask_ff;

   logic [CB-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [CB-1:0] new_x_ff, new_x_in, new_y_ff, new_y_in;
   logic [CB-1:0] base_x_ff, base_x_in, cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [DB-1:0] col_ff, col_in, row_ff, row_in, cols_ff, cols_in, rows_ff, rows_in;
   logic [DB-1:0] w_ff, w_in, h_ff, h_in;
   logic full_ff, full_in;
   logic [sets_pkg::TRIG_BITS-1:0] wdata_ff, wdata_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic pend_valid_ff, pend_valid_in;
   sets_pkg::rsp_word_type pend_ff, pend_in;
   logic rsp_valid_ff, rsp_valid_in;
   sets_pkg::rsp_word_type rsp_ff, rsp_in;

   logic accept;
   logic [DB-1:0] w_clamp, h_clamp;
   logic [CB:0] dx, dy;
   logic small_x, small_y, step_full, dx_zero, dx_one, dy_one;
   logic [DB-1:0] cols_new, rows_new;
   logic [MB-1:0] mx, my;
   logic [CB+1:0] diff_x, diff_y;
   logic in_prev, hit, last_col, last_row;

   sets_pkg::au_req_type au_req;
   logic au_done;
   logic [AW-1:0] au_addr;
   logic ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [sets_pkg::TRIG_BITS-1:0] ram_wr_data;
   logic ram_rd_en;
   logic [sets_pkg::TRIG_BITS-1:0] ram_rd_data;

   assign busy = state_ff != ST_IDLE;
   assign accept = start && !busy;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         view_width_ff <= DB'(8);
         view_height_ff <= DB'(8);
         map_stride_ff <= sets_pkg::STRIDE_BITS'(64);
         x_mask_ff <= MB'(63);
         y_mask_ff <= MB'(63);
      end else if (csr_valid) begin
         unique case (csr_index)
            sets_pkg::CSR_VIEW_WIDTH: view_width_ff <= csr_data[DB-1:0];
            sets_pkg::CSR_VIEW_HEIGHT: view_height_ff <= csr_data[DB-1:0];
            sets_pkg::CSR_MAP_STRIDE: map_stride_ff <= csr_data;
            sets_pkg::CSR_X_MASK: x_mask_ff <= csr_data[MB-1:0];
            sets_pkg::CSR_Y_MASK: y_mask_ff <= csr_data[MB-1:0];
            default: begin
            end
         endcase
      end
   end

   // step classification of an incoming move
   always_comb begin
      w_clamp = (view_width_ff > VIEW_LIMIT) ? VIEW_LIMIT : view_width_ff;
      h_clamp = (view_height_ff > VIEW_LIMIT) ? VIEW_LIMIT : view_height_ff;
      dx = {req.tile_x[CB-1], req.tile_x} - {prev_x_ff[CB-1], prev_x_ff};
      dy = {req.tile_y[CB-1], req.tile_y} - {prev_y_ff[CB-1], prev_y_ff};
      small_x = (dx == DELTA_ZERO) || (dx == DELTA_ONE) || (dx == DELTA_MINUS_ONE);
      small_y = (dy == DELTA_ZERO) || (dy == DELTA_ONE) || (dy == DELTA_MINUS_ONE);
      step_full = !(small_x && small_y);
      dx_zero = dx == DELTA_ZERO;
      dx_one = dx == DELTA_ONE;
      dy_one = dy == DELTA_ONE;
      cols_new = (!step_full && !dx_zero) ? DB'(1) : w_clamp;
      rows_new = (!step_full && dx_zero) ? DB'(1) : h_clamp;
   end

   // tile check against the previous view
   always_comb begin
      mx = cur_x_ff[MB-1:0] & x_mask_ff;
      my = cur_y_ff[MB-1:0] & y_mask_ff;
      diff_x = (CB + 2)'(mx) - {{2{prev_x_ff[CB-1]}}, prev_x_ff};
      diff_y = (CB + 2)'(my) - {{2{prev_y_ff[CB-1]}}, prev_y_ff};
      in_prev = !diff_x[CB+1] && (diff_x < (CB + 2)'(w_ff))
             && !diff_y[CB+1] && (diff_y < (CB + 2)'(h_ff));
      hit = (ram_rd_data != sets_pkg::TRIG_EMPTY) && !(full_ff && in_prev);
      last_col = col_ff == cols_ff - 1'b1;
      last_row = row_ff == rows_ff - 1'b1;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      new_x_in = new_x_ff;
      new_y_in = new_y_ff;
      base_x_in = base_x_ff;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      col_in = col_ff;
      row_in = row_ff;
      cols_in = cols_ff;
      rows_in = rows_ff;
      w_in = w_ff;
      h_in = h_ff;
      full_in = full_ff;
      wdata_in = wdata_ff;
      clr_in = clr_ff;
      pend_valid_in = pend_valid_ff;
      pend_in = pend_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      au_req = '0;
      ram_wr_en = 1'b0;
      ram_wr_addr = au_addr;
      ram_wr_data = wdata_ff;
      ram_rd_en = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = sets_pkg::TRIG_EMPTY;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req.cmd == sets_pkg::CMD_WRITE) begin
                  wdata_in = req.trigger_value;
                  au_req.start = 1'b1;
                  au_req.lookup = 1'b0;
                  state_in = ST_WADDR;
               end else if (!(dx_zero && dy == DELTA_ZERO)) begin
                  new_x_in = req.tile_x;
                  new_y_in = req.tile_y;
                  w_in = w_clamp;
                  h_in = h_clamp;
                  full_in = step_full;
                  cols_in = cols_new;
                  rows_in = rows_new;
                  col_in = '0;
                  row_in = '0;
                  base_x_in = (!step_full && dx_one)
                     ? req.tile_x + CB'(w_clamp) - 1'b1 : req.tile_x;
                  cur_x_in = base_x_in;
                  cur_y_in = (!step_full && dx_zero && dy_one)
                     ? req.tile_y + CB'(h_clamp) - 1'b1 : req.tile_y;
                  pend_valid_in = 1'b0;
                  state_in = (cols_new == '0 || rows_new == '0) ? ST_FLUSH : ST_LOOK;
               end
            end
         end
         ST_WADDR: begin
            if (au_done) begin
               ram_wr_en = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_LOOK: begin
            au_req.start = 1'b1;
            au_req.lookup = 1'b1;
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            if (au_done) begin
               ram_rd_en = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (hit) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = pend_ff;
                  rsp_in.last = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_in.out_tile_x = cur_x_ff;
               pend_in.out_tile_y = cur_y_ff;
               pend_in.trigger_id = ram_rd_data;
               pend_in.last = 1'b0;
            end
            if (last_col) begin
               col_in = '0;
               row_in = row_ff + 1'b1;
               cur_x_in = base_x_ff;
               cur_y_in = cur_y_ff + 1'b1;
               state_in = last_row ? ST_FLUSH : ST_LOOK;
            end else begin
               col_in = col_ff + 1'b1;
               cur_x_in = cur_x_ff + 1'b1;
               state_in = ST_LOOK;
            end
         end
         ST_FLUSH: begin
            if (pend_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in = pend_ff;
               rsp_in.last = 1'b1;
            end
            pend_valid_in = 1'b0;
            prev_x_in = new_x_ff;
            prev_y_in = new_y_ff;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      new_x_ff <= new_x_in;
      new_y_ff <= new_y_in;
      base_x_ff <= base_x_in;
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      col_ff <= col_in;
      row_ff <= row_in;
      cols_ff <= cols_in;
      rows_ff <= rows_in;
      w_ff <= w_in;
      h_ff <= h_in;
      full_ff <= full_in;
      wdata_ff <= wdata_in;
      pend_ff <= pend_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

   sets_addr_unit #(
      .MAP_DEPTH(MAP_DEPTH)
   ) u_addr_unit (
      .clock(clock),
      .reset(reset),
      .au_req(au_req),
      .mask_x(mx),
      .mask_y(my),
      .stride(map_stride_ff),
      .wr_index(req.map_address),
      .done(au_done),
      .addr(au_addr)
   );

   sets_map_ram #(
      .MAP_DEPTH(MAP_DEPTH)
   ) u_map_ram (
      .clock(clock),
      .wr_en(ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en(ram_rd_en),
      .rd_addr(au_addr),
      .rd_data(ram_rd_data)
   );

endmodule
